### rtl/core/assert_macros.svh
// assertion macros used by the rigid body step controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RBES_ASSERT(label, clk_s, rst_n, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define RBES_ASSERT_NEVER(label, clk_s, rst_n, cond, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/rbes_pkg.sv
// types, constants and helpers of the rigid body euler step block
`default_nettype none
package rbes_pkg;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic [16:0] FACTOR_ONE = 17'h10000;
	localparam logic [63:0] FAST_SQ_LIMIT = 64'd400 << 32;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_FORCE = 2'd1,
		KIND_SET   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_FLOOR    = 3'd1,
		REG_BOUNCE   = 3'd2,
		REG_DRAG     = 3'd3,
		REG_FRICTION = 3'd4,
		REG_GRAVITY  = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		MUL_V0_DT,
		MUL_V1_DT,
		MUL_V2_DT,
		MUL_V0_SQ,
		MUL_V1_SQ,
		MUL_V2_SQ,
		MUL_BOUNCE,
		MUL_V0_DRAG,
		MUL_V2_DRAG,
		MUL_V0_FRIC,
		MUL_V2_FRIC,
		MUL_GRAV_DT
	} mul_sel_t;

	typedef enum logic [3:0] {
		WB_NONE,
		WB_POS0,
		WB_POS1,
		WB_POS2,
		WB_ACC_SET,
		WB_ACC_ADD,
		WB_VEL1_BNC,
		WB_VEL0,
		WB_VEL2,
		WB_VEL1_ADD
	} wb_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POS0,
		ST_POS1,
		ST_POS2,
		ST_FLOOR,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SQ3,
		ST_BNC,
		ST_SETV,
		ST_SNAP,
		ST_DRAG1,
		ST_DRAG2,
		ST_FRIC1,
		ST_FRIC2,
		ST_ONF,
		ST_GRAV,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		wb_sel_t  wb_sel;
		logic     load_item;
		logic     clamp;
		logic     set_fast;
		logic     set_vel;
		logic     snap;
		logic     set_onfloor;
		logic     add_force;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       enabled;
		logic       drag_en;
		logic       grav_en;
		logic       hit;
		logic       snap;
		logic       on_floor;
	} status_t;

	// factors above one count as one
	function automatic logic [16:0] sat_factor(input logic [16:0] f);
		sat_factor = (f > FACTOR_ONE) ? FACTOR_ONE : f;
	endfunction

endpackage
`default_nettype wire

### rtl/core/rigid_body_euler_step.sv
// one rigid body stepped by explicit euler ticks with a bouncing floor
// usage:
//  item channel (item_valid/item_stall) carries kind, vec_x/y/z and time_step;
//  the item is taken at an edge with item_valid high and item_stall low.
//  result channel (result_valid/result_stall) returns one result per item:
//  position, velocity and the hit_floor, fast_impact, became_still flags.
//  config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six
//  registers; cfg_ready is always high, writes belong between items.
// sequencing: one shared 33x33 multiplier is stepped by the controller, one
//  product per cycle, so an item takes longer the more multiplies it needs.
//  add force is shorter than set velocity, an enabled tick is longer still
//  (floor hit, drag with friction and gravity are the long path), and a
//  disabled tick or the unused kind 3 is the shortest;
//  the result is valid in the cycle after the output register is loaded.
// reset: arst_n clears position, velocity, on-floor state and the six config registers.
// stall: a finished result waits in the output register; the next item is
//  still taken, and its own result waits until the previous one is taken.
`default_nettype none
module rigid_body_euler_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic [19:0]        time_step,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic signed [31:0]      vel_z,
	output logic                    hit_floor,
	output logic                    fast_impact,
	output logic                    became_still,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	rbes_pkg::cmd_t cmd;
	rbes_pkg::status_t status;

	assign cfg_ready = 1'b1;

	rbes_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	rbes_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.vec_x        (vec_x),
		.vec_y        (vec_y),
		.vec_z        (vec_z),
		.time_step    (time_step),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.hit_floor    (hit_floor),
		.fast_impact  (fast_impact),
		.became_still (became_still)
	);

endmodule
`default_nettype wire

### rtl/core/rbes_dp.sv
// datapath: body state, config registers, shared multiplier and result register
`default_nettype none
module rbes_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rbes_pkg::cmd_t      cmd,
	output rbes_pkg::status_t        status,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic [1:0]          kind,
	input  wire logic signed [31:0]  vec_x,
	input  wire logic signed [31:0]  vec_y,
	input  wire logic signed [31:0]  vec_z,
	input  wire logic [19:0]         time_step,
	output logic signed [31:0]       pos_x,
	output logic signed [31:0]       pos_y,
	output logic signed [31:0]       pos_z,
	output logic signed [31:0]       vel_x,
	output logic signed [31:0]       vel_y,
	output logic signed [31:0]       vel_z,
	output logic                     hit_floor,
	output logic                     fast_impact,
	output logic                     became_still
);

	logic [3:0] mode_q;
	logic [31:0] floor_q;
	logic [16:0] bounce_q;
	logic [16:0] drag_q;
	logic [16:0] friction_q;
	logic [31:0] grav_q;

	logic [1:0] kind_q;
	logic [31:0] vec_q [3];
	logic [19:0] dt_q;

	logic [31:0] pos_q [3];
	logic [31:0] vel_q [3];
	logic on_floor_q;
	logic hit_q;
	logic fast_q;
	logic still_q;

	logic [63:0] prod_q;
	logic [63:0] acc_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic [31:0] q16;
	logic [31:0] bnc;
	logic [16:0] keep_d;
	logic [16:0] keep_f;
	logic small_x;
	logic small_z;
	rbes_pkg::cfg_reg_t cfg_reg;

	assign keep_d = rbes_pkg::FACTOR_ONE - rbes_pkg::sat_factor(drag_q);
	assign keep_f = rbes_pkg::FACTOR_ONE - rbes_pkg::sat_factor(friction_q);
	assign q16 = prod_q[47:16];
	// bounce results under one settle to rest
	assign bnc = ($signed(q16) < rbes_pkg::ONE_Q16) ? 32'd0 : q16;

	assign small_x = ($signed(vel_q[0]) < rbes_pkg::ONE_Q16)
		&& ($signed(vel_q[0]) > -rbes_pkg::ONE_Q16);
	assign small_z = ($signed(vel_q[2]) < rbes_pkg::ONE_Q16)
		&& ($signed(vel_q[2]) > -rbes_pkg::ONE_Q16);

	always_comb begin
		status.kind = kind_q;
		status.enabled = mode_q[0];
		status.drag_en = mode_q[2];
		status.grav_en = mode_q[3];
		status.hit = mode_q[1] && ($signed(pos_q[1]) < $signed(floor_q));
		status.snap = small_x && small_z;
		status.on_floor = on_floor_q;
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			rbes_pkg::MUL_V0_DT: begin
				mul_a = {vel_q[0][31], vel_q[0]};
				mul_b = {13'd0, dt_q};
			end
			rbes_pkg::MUL_V1_DT: begin
				mul_a = {vel_q[1][31], vel_q[1]};
				mul_b = {13'd0, dt_q};
			end
			rbes_pkg::MUL_V2_DT: begin
				mul_a = {vel_q[2][31], vel_q[2]};
				mul_b = {13'd0, dt_q};
			end
			rbes_pkg::MUL_V0_SQ: begin
				mul_a = {vel_q[0][31], vel_q[0]};
				mul_b = {vel_q[0][31], vel_q[0]};
			end
			rbes_pkg::MUL_V1_SQ: begin
				mul_a = {vel_q[1][31], vel_q[1]};
				mul_b = {vel_q[1][31], vel_q[1]};
			end
			rbes_pkg::MUL_V2_SQ: begin
				mul_a = {vel_q[2][31], vel_q[2]};
				mul_b = {vel_q[2][31], vel_q[2]};
			end
			rbes_pkg::MUL_BOUNCE: begin
				mul_a = 33'sd0 - $signed({vel_q[1][31], vel_q[1]});
				mul_b = {16'd0, rbes_pkg::sat_factor(bounce_q)};
			end
			rbes_pkg::MUL_V0_DRAG: begin
				mul_a = {vel_q[0][31], vel_q[0]};
				mul_b = {16'd0, keep_d};
			end
			rbes_pkg::MUL_V2_DRAG: begin
				mul_a = {vel_q[2][31], vel_q[2]};
				mul_b = {16'd0, keep_d};
			end
			rbes_pkg::MUL_V0_FRIC: begin
				mul_a = {vel_q[0][31], vel_q[0]};
				mul_b = {16'd0, keep_f};
			end
			rbes_pkg::MUL_V2_FRIC: begin
				mul_a = {vel_q[2][31], vel_q[2]};
				mul_b = {16'd0, keep_f};
			end
			rbes_pkg::MUL_GRAV_DT: begin
				mul_a = {grav_q[31], grav_q};
				mul_b = {13'd0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign cfg_reg = rbes_pkg::cfg_reg_t'(cfg_index);

	always_ff @(posedge clk) begin
		prod_q <= mul_p[63:0];
		if (cmd.load_item) begin
			kind_q <= kind;
			vec_q[0] <= vec_x;
			vec_q[1] <= vec_y;
			vec_q[2] <= vec_z;
			dt_q <= time_step;
		end
		case (cmd.wb_sel)
			rbes_pkg::WB_ACC_SET: acc_q <= prod_q;
			rbes_pkg::WB_ACC_ADD: acc_q <= acc_q + prod_q;
			default: acc_q <= acc_q;
		endcase
		if (cmd.load_out) begin
			pos_x <= pos_q[0];
			pos_y <= pos_q[1];
			pos_z <= pos_q[2];
			vel_x <= vel_q[0];
			vel_y <= vel_q[1];
			vel_z <= vel_q[2];
			hit_floor <= hit_q;
			fast_impact <= fast_q;
			became_still <= still_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			floor_q <= '0;
			bounce_q <= '0;
			drag_q <= '0;
			friction_q <= '0;
			grav_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg)
				rbes_pkg::REG_MODE:     mode_q <= cfg_data[3:0];
				rbes_pkg::REG_FLOOR:    floor_q <= cfg_data;
				rbes_pkg::REG_BOUNCE:   bounce_q <= cfg_data[16:0];
				rbes_pkg::REG_DRAG:     drag_q <= cfg_data[16:0];
				rbes_pkg::REG_FRICTION: friction_q <= cfg_data[16:0];
				rbes_pkg::REG_GRAVITY:  grav_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			vel_q[0] <= '0;
			vel_q[1] <= '0;
			vel_q[2] <= '0;
			on_floor_q <= 1'b0;
			hit_q <= 1'b0;
			fast_q <= 1'b0;
			still_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				hit_q <= 1'b0;
				fast_q <= 1'b0;
				still_q <= 1'b0;
			end
			if (cmd.wb_sel == rbes_pkg::WB_POS0)
				pos_q[0] <= pos_q[0] + q16;
			if (cmd.wb_sel == rbes_pkg::WB_POS1)
				pos_q[1] <= pos_q[1] + q16;
			if (cmd.wb_sel == rbes_pkg::WB_POS2)
				pos_q[2] <= pos_q[2] + q16;
			if (cmd.clamp) begin
				pos_q[1] <= floor_q;
				hit_q <= 1'b1;
			end
			if (cmd.set_fast)
				fast_q <= (acc_q > rbes_pkg::FAST_SQ_LIMIT);
			if (cmd.snap) begin
				vel_q[0] <= '0;
				vel_q[2] <= '0;
				still_q <= (vel_q[1] == 32'd0);
			end
			if (cmd.set_onfloor)
				on_floor_q <= (vel_q[1] == 32'd0);
			case (cmd.wb_sel)
				rbes_pkg::WB_VEL0:     vel_q[0] <= q16;
				rbes_pkg::WB_VEL2:     vel_q[2] <= q16;
				rbes_pkg::WB_VEL1_BNC: vel_q[1] <= bnc;
				rbes_pkg::WB_VEL1_ADD: vel_q[1] <= vel_q[1] + q16;
				default: ;
			endcase
			if (cmd.add_force) begin
				vel_q[0] <= vel_q[0] + vec_q[0];
				vel_q[1] <= vel_q[1] + vec_q[1];
				vel_q[2] <= vel_q[2] + vec_q[2];
			end
			if (cmd.set_vel) begin
				vel_q[0] <= vec_q[0];
				vel_q[1] <= vec_q[1];
				vel_q[2] <= vec_q[2];
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/rbes_ctrl.sv
// controller: sequences the shared multiplier and state updates for one item
`default_nettype none
`include "assert_macros.svh"
module rbes_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	output logic                    result_valid,
	input  wire logic               result_stall,
	input  wire rbes_pkg::status_t  status,
	output rbes_pkg::cmd_t          cmd
);

	rbes_pkg::state_t state_q;
	rbes_pkg::state_t state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !(out_valid_q && result_stall);
	assign result_valid = out_valid_q;
	assign item_stall = (state_q != rbes_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rbes_pkg::ST_IDLE:
				if (item_valid)
					state_d = rbes_pkg::ST_DECODE;
			rbes_pkg::ST_DECODE: begin
				if (status.kind == rbes_pkg::KIND_TICK)
					state_d = status.enabled ? rbes_pkg::ST_POS0 : rbes_pkg::ST_OUT;
				else if (status.kind == rbes_pkg::KIND_FORCE)
					state_d = rbes_pkg::ST_ADD;
				else if (status.kind == rbes_pkg::KIND_SET)
					state_d = rbes_pkg::ST_SQ0;
				else
					state_d = rbes_pkg::ST_OUT;
			end
			rbes_pkg::ST_POS0:  state_d = rbes_pkg::ST_POS1;
			rbes_pkg::ST_POS1:  state_d = rbes_pkg::ST_POS2;
			rbes_pkg::ST_POS2:  state_d = rbes_pkg::ST_FLOOR;
			rbes_pkg::ST_FLOOR: state_d = status.hit ? rbes_pkg::ST_SQ0 : rbes_pkg::ST_SNAP;
			rbes_pkg::ST_SQ0:   state_d = rbes_pkg::ST_SQ1;
			rbes_pkg::ST_SQ1:   state_d = rbes_pkg::ST_SQ2;
			rbes_pkg::ST_SQ2:   state_d = rbes_pkg::ST_SQ3;
			rbes_pkg::ST_SQ3:
				state_d = (status.kind == rbes_pkg::KIND_TICK) ? rbes_pkg::ST_BNC
					: rbes_pkg::ST_SETV;
			rbes_pkg::ST_BNC:   state_d = rbes_pkg::ST_SNAP;
			rbes_pkg::ST_SETV:  state_d = rbes_pkg::ST_OUT;
			rbes_pkg::ST_SNAP: begin
				// a snapped body has no horizontal speed left to drag
				if (!status.snap && status.drag_en)
					state_d = rbes_pkg::ST_DRAG1;
				else
					state_d = rbes_pkg::ST_ONF;
			end
			rbes_pkg::ST_DRAG1: state_d = rbes_pkg::ST_DRAG2;
			rbes_pkg::ST_DRAG2:
				state_d = status.on_floor ? rbes_pkg::ST_FRIC1 : rbes_pkg::ST_ONF;
			rbes_pkg::ST_FRIC1: state_d = rbes_pkg::ST_FRIC2;
			rbes_pkg::ST_FRIC2: state_d = rbes_pkg::ST_ONF;
			rbes_pkg::ST_ONF:
				state_d = status.grav_en ? rbes_pkg::ST_GRAV : rbes_pkg::ST_OUT;
			rbes_pkg::ST_GRAV:  state_d = rbes_pkg::ST_OUT;
			rbes_pkg::ST_ADD:   state_d = rbes_pkg::ST_OUT;
			rbes_pkg::ST_OUT:
				if (out_free)
					state_d = rbes_pkg::ST_IDLE;
			default: state_d = rbes_pkg::ST_IDLE;
		endcase
	end

	// each state issues at most one multiply; a product is only retired by the state after its issue
	always_comb begin
		cmd = '0;
		cmd.mul_sel = rbes_pkg::MUL_V0_DT;
		cmd.wb_sel = rbes_pkg::WB_NONE;
		case (state_q)
			rbes_pkg::ST_IDLE: cmd.load_item = item_valid;
			rbes_pkg::ST_DECODE: ;
			rbes_pkg::ST_POS0: cmd.mul_sel = rbes_pkg::MUL_V0_DT;
			rbes_pkg::ST_POS1: begin
				cmd.wb_sel = rbes_pkg::WB_POS0;
				cmd.mul_sel = rbes_pkg::MUL_V1_DT;
			end
			rbes_pkg::ST_POS2: begin
				cmd.wb_sel = rbes_pkg::WB_POS1;
				cmd.mul_sel = rbes_pkg::MUL_V2_DT;
			end
			rbes_pkg::ST_FLOOR: begin
				cmd.wb_sel = rbes_pkg::WB_POS2;
				cmd.clamp = status.hit;
			end
			rbes_pkg::ST_SQ0: cmd.mul_sel = rbes_pkg::MUL_V0_SQ;
			rbes_pkg::ST_SQ1: begin
				cmd.wb_sel = rbes_pkg::WB_ACC_SET;
				cmd.mul_sel = rbes_pkg::MUL_V1_SQ;
			end
			rbes_pkg::ST_SQ2: begin
				cmd.wb_sel = rbes_pkg::WB_ACC_ADD;
				cmd.mul_sel = rbes_pkg::MUL_V2_SQ;
			end
			rbes_pkg::ST_SQ3: begin
				cmd.wb_sel = rbes_pkg::WB_ACC_ADD;
				cmd.mul_sel = rbes_pkg::MUL_BOUNCE;
			end
			rbes_pkg::ST_BNC: begin
				cmd.wb_sel = rbes_pkg::WB_VEL1_BNC;
				cmd.set_fast = 1'b1;
			end
			rbes_pkg::ST_SETV: begin
				cmd.set_fast = 1'b1;
				cmd.set_vel = 1'b1;
			end
			rbes_pkg::ST_SNAP: begin
				cmd.snap = status.snap;
				cmd.mul_sel = rbes_pkg::MUL_V0_DRAG;
			end
			rbes_pkg::ST_DRAG1: begin
				cmd.wb_sel = rbes_pkg::WB_VEL0;
				cmd.mul_sel = rbes_pkg::MUL_V2_DRAG;
			end
			rbes_pkg::ST_DRAG2: begin
				cmd.wb_sel = rbes_pkg::WB_VEL2;
				cmd.mul_sel = rbes_pkg::MUL_V0_FRIC;
			end
			rbes_pkg::ST_FRIC1: begin
				cmd.wb_sel = rbes_pkg::WB_VEL0;
				cmd.mul_sel = rbes_pkg::MUL_V2_FRIC;
			end
			rbes_pkg::ST_FRIC2: cmd.wb_sel = rbes_pkg::WB_VEL2;
			rbes_pkg::ST_ONF: begin
				cmd.set_onfloor = 1'b1;
				cmd.mul_sel = rbes_pkg::MUL_GRAV_DT;
			end
			rbes_pkg::ST_GRAV: cmd.wb_sel = rbes_pkg::WB_VEL1_ADD;
			rbes_pkg::ST_ADD: cmd.add_force = 1'b1;
			rbes_pkg::ST_OUT: cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbes_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.load_out || (out_valid_q && result_stall);
		end
	end

	`RBES_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.load_out && out_valid_q && result_stall, "result register overwritten while stalled")
	`RBES_ASSERT(a_accept_decode, clk, arst_n, (item_valid && !item_stall) |=> (state_q == rbes_pkg::ST_DECODE), "accepted item not decoded")
	`RBES_ASSERT(a_bounce_order, clk, arst_n, (state_q == rbes_pkg::ST_BNC) |-> ($past(state_q) == rbes_pkg::ST_SQ3), "bounce without speed check")

endmodule
`default_nettype wire
